[design/mbk_pkg.sv]
// ----------------------------------------------------------------------------
// mbk_pkg: shared types, constants and lookup functions
// Item and result bundles, element codes and the Morse symbol table for the
// beacon keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbk_pkg;

   // field widths fixed by the item format
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int CODE_W  = 7;
   localparam int LEN_W   = 7;
   localparam int SYM_W   = 6;
   localparam int ELEM_W  = 3;
   localparam int EPOS_W  = 3;
   localparam int REP_W   = 16;
   localparam int ELEMS   = 5;

   localparam int MBK_MAX_CHARS = 64;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   // element codes
   localparam logic [ELEM_W-1:0] EL_END  = 3'd0;
   localparam logic [ELEM_W-1:0] EL_DOT  = 3'd1;
   localparam logic [ELEM_W-1:0] EL_DASH = 3'd2;
   localparam logic [ELEM_W-1:0] EL_GAP  = 3'd7;

   // symbol ids: letters, then digits, then space
   localparam logic [SYM_W-1:0] SYM_DIGIT0 = 6'd26;
   localparam logic [SYM_W-1:0] SYM_SPACE  = 6'd36;

   localparam logic [CODE_W-1:0] ASCII_A    = 7'h41;
   localparam logic [CODE_W-1:0] ASCII_Z    = 7'h5A;
   localparam logic [CODE_W-1:0] ASCII_0    = 7'h30;
   localparam logic [CODE_W-1:0] ASCII_9    = 7'h39;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    char_index;
      logic [CODE_W-1:0]   char_code;
   } mbk_item_type;

   typedef struct packed {
      logic                tone_on;
      logic                wrapped;
      logic [REP_W-1:0]    repeat_count;
   } mbk_result_type;

   // map an ASCII code to a symbol id; anything unknown keys as space
   function automatic logic [SYM_W-1:0] code_to_sym(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] d;
      d = '0;
      if (c >= ASCII_A && c <= ASCII_Z) begin
         d = c - ASCII_A;
         return d[SYM_W-1:0];
      end else if (c >= ASCII_0 && c <= ASCII_9) begin
         d = c - ASCII_0;
         return SYM_DIGIT0 + d[SYM_W-1:0];
      end
      return SYM_SPACE;
   endfunction

   // pack five elements, first element in the low bits
   function automatic logic [ELEMS*ELEM_W-1:0] row5(
      input logic [ELEM_W-1:0] e0, input logic [ELEM_W-1:0] e1,
      input logic [ELEM_W-1:0] e2, input logic [ELEM_W-1:0] e3,
      input logic [ELEM_W-1:0] e4);
      return {e4, e3, e2, e1, e0};
   endfunction

   // Morse table: element sequence of each symbol
   function automatic logic [ELEMS*ELEM_W-1:0] sym_row(input logic [SYM_W-1:0] s);
      logic [ELEMS*ELEM_W-1:0] r;
      unique case (s)
         6'd0:  r = row5(EL_DOT,  EL_DASH, EL_END,  EL_END,  EL_END);
         6'd1:  r = row5(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
         6'd2:  r = row5(EL_DASH, EL_DOT,  EL_DASH, EL_DOT,  EL_END);
         6'd3:  r = row5(EL_DASH, EL_DOT,  EL_DOT,  EL_END,  EL_END);
         6'd4:  r = row5(EL_DOT,  EL_END,  EL_END,  EL_END,  EL_END);
         6'd5:  r = row5(EL_DOT,  EL_DOT,  EL_DASH, EL_DOT,  EL_END);
         6'd6:  r = row5(EL_DASH, EL_DASH, EL_DOT,  EL_END,  EL_END);
         6'd7:  r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
         6'd8:  r = row5(EL_DOT,  EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd9:  r = row5(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_END);
         6'd10: r = row5(EL_DASH, EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd11: r = row5(EL_DOT,  EL_DASH, EL_DOT,  EL_DOT,  EL_END);
         6'd12: r = row5(EL_DASH, EL_DASH, EL_END,  EL_END,  EL_END);
         6'd13: r = row5(EL_DASH, EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd14: r = row5(EL_DASH, EL_DASH, EL_DASH, EL_END,  EL_END);
         6'd15: r = row5(EL_DOT,  EL_DASH, EL_DASH, EL_DOT,  EL_END);
         6'd16: r = row5(EL_DASH, EL_DASH, EL_DOT,  EL_DASH, EL_END);
         6'd17: r = row5(EL_DOT,  EL_DASH, EL_DOT,  EL_END,  EL_END);
         6'd18: r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_END,  EL_END);
         6'd19: r = row5(EL_DASH, EL_END,  EL_END,  EL_END,  EL_END);
         6'd20: r = row5(EL_DOT,  EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd21: r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_END);
         6'd22: r = row5(EL_DOT,  EL_DASH, EL_DASH, EL_END,  EL_END);
         6'd23: r = row5(EL_DASH, EL_DOT,  EL_DOT,  EL_DASH, EL_END);
         6'd24: r = row5(EL_DASH, EL_DOT,  EL_DASH, EL_DASH, EL_END);
         6'd25: r = row5(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_END);
         6'd26: r = row5(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DASH);
         6'd27: r = row5(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_DASH);
         6'd28: r = row5(EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_DASH);
         6'd29: r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_DASH);
         6'd30: r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH);
         6'd31: r = row5(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT);
         6'd32: r = row5(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT);
         6'd33: r = row5(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_DOT);
         6'd34: r = row5(EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_DOT);
         6'd35: r = row5(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DOT);
         default: r = row5(EL_GAP, EL_END, EL_END, EL_END, EL_END);
      endcase
      return r;
   endfunction

   // element at a position of a symbol; past the last slot reads as end
   function automatic logic [ELEM_W-1:0] elem_of(input logic [SYM_W-1:0] s,
                                                 input logic [EPOS_W-1:0] el);
      logic [ELEMS*ELEM_W-1:0] r;
      r = sym_row(s);
      if (el >= EPOS_W'(ELEMS)) return EL_END;
      return r[el*ELEM_W +: ELEM_W];
   endfunction

endpackage

`default_nettype wire

[design/mbk_ram.sv]
// ----------------------------------------------------------------------------
// mbk_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/mbk_core.sv]
// ----------------------------------------------------------------------------
// mbk_core: keyer state and per-beat update
// Holds the message store, the playback position and cached symbols for the
// current, next and first characters, and works out one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mbk_core #(
   parameter int MAX_CHARS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  mbk_pkg::mbk_item_type             item,
   input  logic [mbk_pkg::LEN_W-1:0]         length,
   output mbk_pkg::mbk_result_type           result
);
   import mbk_pkg::*;

   localparam int CP_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int CLOG_MAX = $clog2(MAX_CHARS + 1);
   localparam int CNT_W = (CLOG_MAX > LEN_W) ? CLOG_MAX : LEN_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

   // playback state
   logic [CP_W-1:0]   cp_ff, cp_in;
   logic [EPOS_W-1:0] ep_ff, ep_in;
   logic [ELEM_W-1:0] ttl_ff, ttl_in;
   logic [REP_W-1:0]  rep_ff, rep_in;
   logic              armed_ff, armed_in;
   // cached symbols: current, following and first character
   logic [SYM_W-1:0]  cur_sym_ff, cur_sym_in;
   logic [SYM_W-1:0]  next_sym_ff, next_sym_in;
   logic [SYM_W-1:0]  sym0_ff, sym0_in;
   logic              fill_ff, fill_in;

   logic              wr_en, rd_en;
   logic [CP_W-1:0]   wr_addr, rd_addr;
   logic [SYM_W-1:0]  wr_sym, rd_sym;
   logic [CNT_W-1:0]  len_ext, eff_len, cp_plus1, idx_ext, new_plus1;
   logic [CP_W-1:0]   new_cp;
   logic [SYM_W-1:0]  new_sym;
   logic              tone, wrap;

   // clamp the message length into 1..MAX_CHARS
   always_comb begin
      len_ext = CNT_W'(length);
      eff_len = len_ext;
      if (len_ext == '0) eff_len = CNT_W'(1);
      if (len_ext > MAX_CNT) eff_len = MAX_CNT;
   end

   assign cp_plus1 = CNT_W'(cp_ff) + CNT_W'(1);
   assign idx_ext  = CNT_W'(item.char_index);
   assign wr_sym   = code_to_sym(item.char_code);
   assign wr_addr  = CP_W'(item.char_index);

   // per-beat update
   always_comb begin
      cp_in       = cp_ff;
      ep_in       = ep_ff;
      ttl_in      = ttl_ff;
      rep_in      = rep_ff;
      armed_in    = armed_ff;
      cur_sym_in  = cur_sym_ff;
      next_sym_in = next_sym_ff;
      sym0_in     = sym0_ff;
      tone        = 1'b0;
      wrap        = 1'b0;
      wr_en       = 1'b0;
      new_cp      = cp_ff;
      new_sym     = cur_sym_ff;
      rd_en       = 1'b0;

      // land the prefetched following symbol
      if (fill_ff) next_sym_in = rd_sym;

      if (fire) begin
         case (item.op)
            OP_WRITE: begin
               if (idx_ext < MAX_CNT) begin
                  wr_en = 1'b1;
                  if (idx_ext == CNT_W'(cp_ff)) cur_sym_in = wr_sym;
                  if (idx_ext == cp_plus1) next_sym_in = wr_sym;
                  if (idx_ext == '0) sym0_in = wr_sym;
               end
            end
            OP_RESTART: begin
               armed_in   = 1'b1;
               new_cp     = '0;
               cp_in      = '0;
               ep_in      = '0;
               rep_in     = '0;
               cur_sym_in = sym0_ff;
               ttl_in     = elem_of(sym0_ff, '0);
               rd_en      = 1'b1;
            end
            OP_TICK: begin
               if (armed_ff) begin
                  if (ttl_ff == EL_GAP) begin
                     ttl_in = EL_END;
                  end else if (ttl_ff != EL_END) begin
                     ttl_in = ttl_ff - ELEM_W'(1);
                     tone   = 1'b1;
                  end else if (elem_of(cur_sym_ff, ep_ff + EPOS_W'(1)) == EL_END) begin
                     // character done: step to the next one or wrap
                     if (cp_plus1 >= eff_len) begin
                        new_cp  = '0;
                        new_sym = sym0_ff;
                        rep_in  = rep_ff + REP_W'(1);
                        wrap    = 1'b1;
                     end else begin
                        new_cp  = CP_W'(cp_plus1);
                        new_sym = next_sym_ff;
                     end
                     cp_in      = new_cp;
                     ep_in      = '0;
                     cur_sym_in = new_sym;
                     ttl_in     = elem_of(new_sym, '0);
                     rd_en      = 1'b1;
                  end else begin
                     ep_in  = ep_ff + EPOS_W'(1);
                     ttl_in = elem_of(cur_sym_ff, ep_ff + EPOS_W'(1));
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // prefetch the character after the new position when it exists
      new_plus1 = CNT_W'(new_cp) + CNT_W'(1);
      if (new_plus1 >= MAX_CNT) rd_en = 1'b0;
      rd_addr = CP_W'(new_plus1);
      fill_in = rd_en;
   end

   mbk_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_CHARS),
      .ADDR_W(CP_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_sym),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_sym)
   );

   // hold state; clear control on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff    <= '0;
         ep_ff    <= '0;
         ttl_ff   <= EL_END;
         rep_ff   <= '0;
         armed_ff <= 1'b0;
         fill_ff  <= 1'b0;
      end else begin
         cp_ff    <= cp_in;
         ep_ff    <= ep_in;
         ttl_ff   <= ttl_in;
         rep_ff   <= rep_in;
         armed_ff <= armed_in;
         fill_ff  <= fill_in;
      end
      cur_sym_ff  <= cur_sym_in;
      next_sym_ff <= next_sym_in;
      sym0_ff     <= sym0_in;
   end

   assign result.tone_on      = tone;
   assign result.wrapped      = wrap;
   assign result.repeat_count = rep_in;

   // tone counter only ever holds dash, dot, done or extra gap
   assert property (@(posedge clock) disable iff (reset)
      (ttl_ff == EL_END || ttl_ff == EL_DOT || ttl_ff == EL_DASH || ttl_ff == EL_GAP))
      else $error("mbk_core: tone counter holds an illegal value");

   // element position stays inside the symbol
   assert property (@(posedge clock) disable iff (reset)
      ep_ff < EPOS_W'(ELEMS))
      else $error("mbk_core: element position out of range");

   // a wrap beat is silent and bumps the repeat count
   assert property (@(posedge clock) disable iff (reset)
      (fire && wrap) |-> (!tone && rep_in == rep_ff + REP_W'(1)))
      else $error("mbk_core: wrap beat sounded or missed its count");

   // the keyer stays armed once armed until reset
   assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("mbk_core: keyer disarmed without reset");

endmodule

`default_nettype wire

[design/morse_beacon_keyer.sv]
// ----------------------------------------------------------------------------
// morse_beacon_keyer: repeating Morse beacon keyer
// Input register, keyer core and result register with valid/ready on both
// channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per beat: a tick, a character write into the
//   message store, or a restart that arms playback from character 0.
//   rsp_* returns exactly one result per item, in order: the tone bit, the
//   wrap flag and the repeat count. csr_wr_en/csr_wr_data set the message
//   length; write it only while no item is in flight.
// Timing: an accepted item waits in the input register, then moves through
//   the core into the result register, where rsp_valid rises; a full result
//   register keeps it waiting in the input register.
// Throughput: one item per cycle unless stalled; each is a symbol table lookup
//   and a counter update between the two registers, and the message store is
//   read one character ahead so its registered read never stalls a beat.
// Reset: playback disarmed, repeat count zero, message length one; the
//   message store is not cleared and must be written before it is played.
// Stall: while rsp_ready is low the result holds, the input register keeps
//   one more item, and req_ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_beacon_keyer #(
   parameter int MAX_CHARS = mbk_pkg::MBK_MAX_CHARS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mbk_pkg::OP_W-1:0]     req_op,
   input  logic [mbk_pkg::IDX_W-1:0]    req_char_index,
   input  logic [mbk_pkg::CODE_W-1:0]   req_char_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_tone_on,
   output logic                         rsp_wrapped,
   output logic [mbk_pkg::REP_W-1:0]    rsp_repeat_count,
   input  logic                         csr_wr_en,
   input  logic [mbk_pkg::LEN_W-1:0]    csr_wr_data
);
   import mbk_pkg::*;

   logic           in_valid_ff, in_valid_in;
   mbk_item_type   item_ff, item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   mbk_result_type rsp_ff, rsp_in;
   logic [LEN_W-1:0] length_ff;
   mbk_result_type result;
   logic           advance;

   // move the held item into the result register when it has room
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         item_in     = '{op: op_type'(req_op), char_index: req_char_index,
                         char_code: req_char_code};
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   mbk_core #(
      .MAX_CHARS(MAX_CHARS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .length(length_ff),
      .result(result)
   );

   // hold registers; clear valids and length on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= LEN_W'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) length_ff <= csr_wr_data;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone_on      = rsp_ff.tone_on;
   assign rsp_wrapped      = rsp_ff.wrapped;
   assign rsp_repeat_count = rsp_ff.repeat_count;

   // a blocked item stays in the input register untouched
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("morse_beacon_keyer: held item lost or changed");

   // every item moved on shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("morse_beacon_keyer: result missing after advance");

   // reset empties both registers
   assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_valid_ff))
      else $error("morse_beacon_keyer: registers not empty after reset");

endmodule

`default_nettype wire

[bench/morse_beacon_keyer_checker.sv]
// ----------------------------------------------------------------------------
// morse_beacon_keyer_checker: result predictor and comparator for the keyer
// Watches the request, result and length-register ports. Every request beat
// runs through an independent model of the Morse keyer, and the tone, wrap
// and repeat count it yields are queued. Each result beat is compared field by
// field with the oldest queued entry. Mismatches are counted and handed up.
// ----------------------------------------------------------------------------
module morse_beacon_keyer_checker #(
   parameter int MAX_CHARS = mbk_pkg::MBK_MAX_CHARS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [mbk_pkg::OP_W-1:0]     req_op,
   input  logic [mbk_pkg::IDX_W-1:0]    req_char_index,
   input  logic [mbk_pkg::CODE_W-1:0]   req_char_code,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_tone_on,
   input  logic                         rsp_wrapped,
   input  logic [mbk_pkg::REP_W-1:0]    rsp_repeat_count,
   input  logic                         csr_wr_en,
   input  logic [mbk_pkg::LEN_W-1:0]    csr_wr_data,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import mbk_pkg::*;

   // keyer state as the model sees it
   logic [SYM_W-1:0]   msg_sym [MAX_CHARS];
   logic [LEN_W-1:0]   msg_len;
   logic [IDX_W-1:0]   play_char;
   logic [EPOS_W-1:0]  play_elem;
   logic [ELEM_W-1:0]  tone_left;
   logic [REP_W-1:0]   rep_total;
   logic               keyer_armed;

   mbk_result_type     keyed_q [$];
   int                 mismatches = 0;

   // dots and dashes of each letter and digit, in symbol id order
   function automatic string morse_of(int unsigned sym);
      case (sym)
         0:  return ".-";     1:  return "-...";   2:  return "-.-.";
         3:  return "-..";    4:  return ".";      5:  return "..-.";
         6:  return "--.";    7:  return "....";   8:  return "..";
         9:  return ".---";   10: return "-.-";    11: return ".-..";
         12: return "--";     13: return "-.";     14: return "---";
         15: return ".--.";   16: return "--.-";   17: return ".-.";
         18: return "...";    19: return "-";      20: return "..-";
         21: return "...-";   22: return ".--";    23: return "-..-";
         24: return "-.--";   25: return "--..";
         26: return "-----";  27: return ".----";  28: return "..---";
         29: return "...--";  30: return "....-";  31: return ".....";
         32: return "-....";  33: return "--...";  34: return "---..";
         35: return "----.";
         default: return "";
      endcase
   endfunction

   // element code at one slot of a symbol; space is a lone extra gap
   function automatic logic [ELEM_W-1:0] element_at(logic [SYM_W-1:0] sym,
                                                    int unsigned pos);
      string pattern;
      if (sym >= SYM_SPACE) return (pos == 0) ? EL_GAP : EL_END;
      pattern = morse_of(sym);
      if (pos >= pattern.len()) return EL_END;
      return (pattern[pos] == "-") ? EL_DASH : EL_DOT;
   endfunction

   // letters and digits key as themselves, anything else as space
   function automatic logic [SYM_W-1:0] symbol_of(logic [CODE_W-1:0] code);
      int c;
      c = code;
      if (c >= "A" && c <= "Z") return SYM_W'(c - "A");
      if (c >= "0" && c <= "9") return SYM_W'(c - "0" + 26);
      return SYM_SPACE;
   endfunction

   // message length clamped into 1..MAX_CHARS
   function automatic int play_span();
      if (msg_len == 0) return 1;
      if (int'(msg_len) > MAX_CHARS) return MAX_CHARS;
      return int'(msg_len);
   endfunction

   // advance the keyer by one request and return the result it produces
   function automatic mbk_result_type key_beat(logic [OP_W-1:0] op,
                                               logic [IDX_W-1:0] idx,
                                               logic [CODE_W-1:0] code);
      mbk_result_type res;
      res = '0;
      case (op)
         OP_WRITE: begin
            if (int'(idx) < MAX_CHARS) msg_sym[idx] = symbol_of(code);
         end
         OP_RESTART: begin
            keyer_armed = 1'b1;
            play_char   = '0;
            play_elem   = '0;
            rep_total   = '0;
            tone_left   = element_at(msg_sym[0], 0);
         end
         OP_TICK: begin
            if (keyer_armed) begin
               if (tone_left == EL_GAP) begin
                  // burn the extra silent tick of a space
                  tone_left = EL_END;
               end else if (tone_left != EL_END) begin
                  tone_left   = tone_left - 1'b1;
                  res.tone_on = 1'b1;
               end else begin
                  // silent tick after an element: step to the next one
                  if (element_at(msg_sym[play_char], play_elem + 1) == EL_END) begin
                     if (int'(play_char) + 1 >= play_span()) begin
                        play_char   = '0;
                        rep_total   = rep_total + 1'b1;
                        res.wrapped = 1'b1;
                     end else begin
                        play_char = play_char + 1'b1;
                     end
                     play_elem = '0;
                  end else begin
                     play_elem = play_elem + 1'b1;
                  end
                  tone_left = element_at(msg_sym[play_char], play_elem);
               end
            end
         end
         default: ;
      endcase
      res.repeat_count = rep_total;
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want,
                                       int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // compare results first, then log the length write, then predict requests
   always @(posedge clock) begin : monitor
      mbk_result_type want;
      if (reset) begin
         msg_len     = LEN_W'(1);
         play_char   = '0;
         play_elem   = '0;
         tone_left   = EL_END;
         rep_total   = '0;
         keyer_armed = 1'b0;
         keyed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (keyed_q.size() == 0) begin
               $error("result beat with nothing outstanding: tone_on %0d wrapped %0d count %0d",
                      rsp_tone_on, rsp_wrapped, rsp_repeat_count);
               mismatches++;
            end else begin
               want = keyed_q.pop_front();
               check_field("tone_on", want.tone_on, rsp_tone_on);
               check_field("wrapped", want.wrapped, rsp_wrapped);
               check_field("repeat_count", want.repeat_count, rsp_repeat_count);
            end
         end
         if (csr_wr_en) msg_len = csr_wr_data;
         if (req_valid && req_ready)
            keyed_q.push_back(key_beat(req_op, req_char_index, req_char_code));
      end
      outstanding <= keyed_q.size();
      fail_count  <= mismatches;
   end

endmodule

[bench/morse_beacon_keyer_test.sv]
// ----------------------------------------------------------------------------
// morse_beacon_keyer_test: top-level testbench of the Morse beacon keyer
// Drives a short directed sequence and then phases of random traffic, each
// under its own message length, with random stalls on both channels. The
// checker beside the block predicts and compares every result; this module
// only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module morse_beacon_keyer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mbk_pkg::*;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;   // undecoded op, must be ignored
   localparam int PHASE_BEATS   = 150;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op           = '0;
   logic [IDX_W-1:0]    req_char_index   = '0;
   logic [CODE_W-1:0]   req_char_code    = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic                rsp_tone_on;
   logic                rsp_wrapped;
   logic [REP_W-1:0]    rsp_repeat_count;
   logic                csr_wr_en        = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data      = '0;

   int                  fail_count;
   int                  outstanding;
   int                  beats_sent       = 0;
   int                  sender_idle      = 14;
   int                  receiver_idle    = 83;
   bit                  msg_written [MBK_MAX_CHARS];

   morse_beacon_keyer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_char_index   (req_char_index),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tone_on      (rsp_tone_on),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_repeat_count (rsp_repeat_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   morse_beacon_keyer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_char_index   (req_char_index),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tone_on      (rsp_tone_on),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_repeat_count (rsp_repeat_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   // present one request beat, hold it until taken, then maybe idle a while
   task automatic send_beat(input logic [OP_W-1:0] op, input int idx, input int code);
      // receiver slow first, sender slow next, then full rate
      if (beats_sent < 480) begin
         sender_idle = 14;
         receiver_idle <= 83;
      end else if (beats_sent < 960) begin
         sender_idle = 83;
         receiver_idle <= 14;
      end else begin
         sender_idle = 0;
         receiver_idle <= 0;
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_char_index <= idx[IDX_W-1:0];
      req_char_code  <= code[CODE_W-1:0];
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (op == OP_WRITE) msg_written[idx[IDX_W-1:0]] = 1'b1;
      if ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle);
      end
   endtask

   // drop valid and wait until every predicted result has been seen
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write the message length while the keyer is idle
   task automatic set_length(input int len);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len[LEN_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly letters, digits and spaces, sometimes any 7-bit code
   function automatic int random_code();
      case ($urandom_range(3))
         0: return int'(ASCII_A) + $urandom_range(25);
         1: return int'(ASCII_0) + $urandom_range(9);
         2: return 32;
         default: return $urandom_range(127);
      endcase
   endfunction

   initial begin : stimulus
      int phase_len [9];
      int eff_len;
      int phase_start;
      int pick;
      phase_len = '{0, 3, 127, 1, 2, 64, 5, 11, 1};
      phase_len[8] = $urandom_range(64, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks before arming and the undecoded op stay silent
      send_beat(OP_TICK, 63, 127);
      send_beat(OP_NONE, 0, 0);
      // codes outside A-Z and 0-9 key as space
      send_beat(OP_WRITE, 63, 127);
      send_beat(OP_WRITE, 0, 0);
      send_beat(OP_RESTART, 0, 0);
      repeat (3) send_beat(OP_TICK, 0, 0);
      // field extremes of the letter and digit ranges
      send_beat(OP_WRITE, 1, int'(ASCII_Z));
      send_beat(OP_WRITE, 2, int'(ASCII_0));
      send_beat(OP_WRITE, 3, int'(ASCII_9));
      // Q is one of the corrected table entries
      send_beat(OP_WRITE, 0, int'(ASCII_A) + 16);
      send_beat(OP_RESTART, 0, 0);
      repeat (8) send_beat(OP_TICK, 0, 0);

      for (int p = 0; p < 9; p++) begin
         set_length(phase_len[p]);
         eff_len = (phase_len[p] < 1) ? 1 :
                   (phase_len[p] > MBK_MAX_CHARS) ? MBK_MAX_CHARS : phase_len[p];
         // fill the part of the message the keyer may now reach
         for (int i = 0; i < eff_len; i++)
            if (!msg_written[i]) send_beat(OP_WRITE, i, random_code());
         // after the long message keep playing, so the position lands past the end
         if (p != 6 && $urandom_range(1))
            send_beat(OP_RESTART, $urandom_range(63), $urandom_range(127));
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            pick = $urandom_range(99);
            if (pick < 78)
               send_beat(OP_TICK, $urandom_range(63), $urandom_range(127));
            else if (pick < 90)
               send_beat(OP_WRITE, $urandom_range(63), random_code());
            else if (pick < 95)
               send_beat(OP_RESTART, $urandom_range(63), $urandom_range(127));
            else
               send_beat(OP_NONE, $urandom_range(63), $urandom_range(127));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** morse_beacon_keyer: PASSED **");
      else
         $display("** morse_beacon_keyer: FAILED **");
      $finish;
   end

   // end a hung run
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timed out after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, outstanding);
      $display("** morse_beacon_keyer: FAILED **");
      $finish;
   end

endmodule

[files.f]
design/mbk_pkg.sv
design/mbk_ram.sv
design/mbk_core.sv
design/morse_beacon_keyer.sv
bench/morse_beacon_keyer_checker.sv
bench/morse_beacon_keyer_test.sv
